// ===== rtl/sept_pkg.sv =====
`default_nettype none
package sept_pkg;

  localparam int unsigned FRAME_HEIGHT = 60;
  localparam int unsigned FRAME_WIDTH  = 80;
  localparam int unsigned PIXELS       = FRAME_HEIGHT * FRAME_WIDTH;

  localparam int unsigned ADDR_W = $clog2(PIXELS);
  localparam int unsigned ROW_W  = $clog2(FRAME_HEIGHT);
  localparam int unsigned COL_W  = $clog2(FRAME_WIDTH);
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned THR_W  = 9;
  localparam int unsigned BINS   = 256;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);
  localparam logic [ADDR_W-1:0] SCAN_LAST = ADDR_W'((FRAME_HEIGHT - 2) * FRAME_WIDTH - 1);
  localparam logic [ADDR_W-1:0] W_ADDR    = ADDR_W'(FRAME_WIDTH);
  localparam logic [ADDR_W-1:0] W2_ADDR   = ADDR_W'(2 * FRAME_WIDTH);
  localparam logic [ADDR_W-1:0] W1_ADDR   = ADDR_W'(FRAME_WIDTH - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(FRAME_HEIGHT - 1);
  localparam logic [CNT_W-1:0]  TARGET_RESET = CNT_W'(233);

  localparam logic [1:0] PH_TOP = 2'd0;
  localparam logic [1:0] PH_MID = 2'd1;
  localparam logic [1:0] PH_BOT = 2'd2;
  localparam logic [1:0] PH_ROW = 2'd3;

  typedef struct packed {
    logic       load;
    logic       read;
    logic       clr;
    logic       scan;
    logic       settle;
    logic       walk;
    logic [1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic last_load;
    logic clr_end;
    logic scan_end;
    logic walk_done;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/sept_ctrl.sv =====
`default_nettype none
module sept_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_action_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire sept_pkg::sts_t sts_i,
  output sept_pkg::cmd_t     cmd_o,
  output logic               busy_o
);
  import sept_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_SETTLE = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  logic       acc;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign busy_o      = (state_q != ST_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = acc && !in_action_i;
    cmd_o.read   = acc && in_action_i;
    cmd_o.clr    = (state_q == ST_CLEAR);
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.settle = (state_q == ST_SETTLE);
    cmd_o.walk   = (state_q == ST_WALK);
    cmd_o.phase  = phase_q;
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.read) out_valid_d = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.load && sts_i.last_load) state_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        phase_d = PH_TOP;
        if (sts_i.clr_end) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        phase_d = phase_q + 2'd1;
        if (phase_q == PH_ROW && sts_i.scan_end) state_d = ST_SETTLE;
      end
      ST_SETTLE: state_d = ST_WALK;
      ST_WALK: begin
        if (sts_i.walk_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_TOP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sept_dp.sv =====
`default_nettype none
module sept_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire sept_pkg::cmd_t             cmd_i,
  output sept_pkg::sts_t                  sts_o,
  input  wire logic [7:0]                 pixel_in_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [sept_pkg::CNT_W-1:0] cfg_wdata_i,
  output logic [7:0]                      pixel_out_o,
  output logic                            is_last_o,
  output logic [sept_pkg::THR_W-1:0]      threshold_used_o,
  output logic                            not_ready_o
);
  import sept_pkg::*;

  logic [7:0]       frame_mem [PIXELS];
  logic [7:0]       mag_mem   [PIXELS];
  logic [CNT_W-1:0] hist_mem  [BINS];

  logic [CNT_W-1:0]  cfg_q, tgt_q;
  logic [ADDR_W-1:0] ld_addr_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic [ROW_W-1:0]  rd_row_q;
  logic [COL_W-1:0]  rd_col_q;
  logic              fc_q;
  logic signed [THR_W-1:0] thr_q;

  // scan state
  logic [ADDR_W-1:0] top_addr_q;
  logic [COL_W-1:0]  scol_q;
  logic [7:0] top_q, mid_q;
  logic [7:0] w0t_q, w0m_q, w0b_q, w1t_q, w1m_q, w1b_q;
  logic       hw_q;
  logic [7:0] m_q;

  // histogram walk
  logic [7:0]       hbin_q, wbin_q;
  logic             wv_q;
  logic [CNT_W-1:0] wsum_q;

  // memory read data and result registers
  logic [7:0]       f_rdata_q, mag_rdata_q;
  logic [CNT_W-1:0] h_rdata_q;
  logic             nr_q, border_q, last_q;
  logic signed [THR_W-1:0] thr_out_q;

  logic              f_re;
  logic [ADDR_W-1:0] f_raddr;
  logic              ph3, mag_we;
  logic [7:0]        mag;
  logic              h_we, h_re;
  logic [7:0]        h_waddr, h_raddr;
  logic [CNT_W-1:0]  h_wdata;
  logic [CNT_W-1:0]  sum_n;
  logic              hit;
  logic signed [THR_W-1:0] thr_new;

  // Sobel on the three-column window; new column is top_q, mid_q, f_rdata_q
  logic [9:0]  s_top, s_bot, s_lft, s_rgt;
  logic [10:0] dx, dy;
  logic [7:0]  gx, gy;

  always_comb begin
    s_top = 10'(w0t_q) + {1'b0, w1t_q, 1'b0} + 10'(top_q);
    s_bot = 10'(w0b_q) + {1'b0, w1b_q, 1'b0} + 10'(f_rdata_q);
    s_lft = 10'(w0t_q) + {1'b0, w0m_q, 1'b0} + 10'(w0b_q);
    s_rgt = 10'(top_q) + {1'b0, mid_q, 1'b0} + 10'(f_rdata_q);
    dx    = {1'b0, s_bot} - {1'b0, s_top};
    dy    = {1'b0, s_lft} - {1'b0, s_rgt};
    gx    = dx[10] ? 8'(-dx) : dx[7:0];
    gy    = dy[10] ? 8'(-dy) : dy[7:0];
    mag   = gx + gy;
  end

  assign ph3    = cmd_i.scan && (cmd_i.phase == PH_ROW);
  assign mag_we = ph3 && (scol_q >= COL_W'(2));

  always_comb begin
    f_re    = cmd_i.read || (cmd_i.scan && (cmd_i.phase != PH_ROW));
    f_raddr = rd_addr_q;
    if (cmd_i.scan) begin
      case (cmd_i.phase)
        PH_TOP:  f_raddr = top_addr_q;
        PH_MID:  f_raddr = top_addr_q + W_ADDR;
        default: f_raddr = top_addr_q + W2_ADDR;
      endcase
    end
  end

  always_comb begin
    h_we    = cmd_i.clr || hw_q;
    h_waddr = cmd_i.clr ? hbin_q : m_q;
    h_wdata = cmd_i.clr ? '0 : h_rdata_q + CNT_W'(1);
    h_re    = mag_we || cmd_i.walk;
    h_raddr = cmd_i.walk ? hbin_q : mag;
  end

  always_comb begin
    sum_n   = wsum_q + h_rdata_q;
    hit     = (sum_n >= tgt_q);
    if (tgt_q == '0)      thr_new = THR_W'(255);
    else if (hit)         thr_new = $signed({1'b0, wbin_q}) - THR_W'(1);
    else                  thr_new = -THR_W'(1);
  end

  always_comb begin
    sts_o.last_load = (ld_addr_q == LAST_ADDR);
    sts_o.clr_end   = (hbin_q == 8'hFF);
    sts_o.scan_end  = (top_addr_q == SCAN_LAST);
    sts_o.walk_done = cmd_i.walk && ((tgt_q == '0) || (wv_q && (hit || wbin_q == 8'd0)));
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) frame_mem[ld_addr_q] <= pixel_in_i;
    if (f_re) f_rdata_q <= frame_mem[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mag_we) mag_mem[top_addr_q + W1_ADDR] <= mag;
    if (cmd_i.read) mag_rdata_q <= mag_mem[rd_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) hist_mem[h_waddr] <= h_wdata;
    if (h_re) h_rdata_q <= hist_mem[h_raddr];
  end

  // window and walk payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && cmd_i.phase == PH_MID) top_q <= f_rdata_q;
    if (cmd_i.scan && cmd_i.phase == PH_BOT) mid_q <= f_rdata_q;
    if (ph3) begin
      w0t_q <= w1t_q;
      w0m_q <= w1m_q;
      w0b_q <= w1b_q;
      w1t_q <= top_q;
      w1m_q <= mid_q;
      w1b_q <= f_rdata_q;
      m_q   <= mag;
    end
    if (cmd_i.walk) begin
      wbin_q <= hbin_q;
      if (wv_q) wsum_q <= sum_n;
    end else begin
      wsum_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      nr_q      <= !fc_q;
      thr_out_q <= thr_q;
      border_q  <= (rd_row_q == '0) || (rd_col_q == '0) ||
                   (rd_row_q == LAST_ROW) || (rd_col_q == LAST_COL);
      last_q    <= fc_q && (rd_addr_q == LAST_ADDR);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= TARGET_RESET;
      tgt_q      <= TARGET_RESET;
      ld_addr_q  <= '0;
      rd_addr_q  <= '0;
      rd_row_q   <= '0;
      rd_col_q   <= '0;
      fc_q       <= 1'b0;
      thr_q      <= THR_W'(255);
      top_addr_q <= '0;
      scol_q     <= '0;
      hw_q       <= 1'b0;
      hbin_q     <= '0;
      wv_q       <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      hw_q <= mag_we;

      if (cmd_i.load) begin
        if (fc_q) begin
          fc_q      <= 1'b0;
          rd_addr_q <= '0;
          rd_row_q  <= '0;
          rd_col_q  <= '0;
        end
        if (sts_o.last_load) begin
          ld_addr_q  <= '0;
          tgt_q      <= cfg_q;
          hbin_q     <= '0;
          top_addr_q <= '0;
          scol_q     <= '0;
        end else begin
          ld_addr_q <= ld_addr_q + ADDR_W'(1);
        end
      end

      if (cmd_i.read && fc_q) begin
        if (rd_addr_q == LAST_ADDR) begin
          rd_addr_q <= '0;
          rd_row_q  <= '0;
          rd_col_q  <= '0;
        end else begin
          rd_addr_q <= rd_addr_q + ADDR_W'(1);
          if (rd_col_q == LAST_COL) begin
            rd_col_q <= '0;
            rd_row_q <= rd_row_q + ROW_W'(1);
          end else begin
            rd_col_q <= rd_col_q + COL_W'(1);
          end
        end
      end

      if (cmd_i.clr) hbin_q <= hbin_q + 8'd1;

      if (ph3) begin
        top_addr_q <= top_addr_q + ADDR_W'(1);
        scol_q     <= (scol_q == LAST_COL) ? '0 : scol_q + COL_W'(1);
      end

      if (cmd_i.settle) begin
        hbin_q <= 8'hFF;
        wv_q   <= 1'b0;
      end
      if (cmd_i.walk) begin
        hbin_q <= hbin_q - 8'd1;
        wv_q   <= 1'b1;
      end
      if (sts_o.walk_done) begin
        thr_q     <= thr_new;
        fc_q      <= 1'b1;
        rd_addr_q <= '0;
        rd_row_q  <= '0;
        rd_col_q  <= '0;
      end
    end
  end

  always_comb begin
    if (nr_q)                                        pixel_out_o = 8'h00;
    else if (border_q)                               pixel_out_o = f_rdata_q;
    else if ($signed({1'b0, mag_rdata_q}) > thr_out_q) pixel_out_o = 8'hFF;
    else                                             pixel_out_o = 8'h00;
  end

  assign is_last_o        = last_q;
  assign threshold_used_o = thr_out_q;
  assign not_ready_o      = nr_q;

endmodule
`default_nettype wire

// ===== rtl/sobel_edge_percentile_threshold.sv =====
// Sobel edge detector with a histogram-derived threshold, one 60x80 frame.
// Slave stream: tuser = action (0 load pixel, 1 read result), tdata = pixel.
// Loads write the frame in raster order, one beat per cycle while tready is high, no result.
// Reads return one master beat each, one per cycle unless stalled, valid the cycle after
// acceptance: tdata = pixel_out, threshold; tuser = not_ready; tlast = end
// of frame readout. A read before a full frame gives a not_ready beat.
// After the last pixel of a frame is loaded the block is busy (tready low):
// it clears the histogram, runs the magnitude scan (three frame-memory
// reads per column through one port, then a window shift), passes a settle
// state, then walks the histogram down from bin 255.
// The edge_target_count register is sampled when the last pixel loads.
// Reset clears positions, the frame-ready flag, sets threshold to 255 and
// the register to 233; the stores need no clearing.
// While the receiver stalls, the result beat holds and tready stays low.
`default_nettype none
module sobel_edge_percentile_threshold (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] pixel_in
  input  wire logic        s_axis_tuser,  // [0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [7:0] pixel_out, [16:8] threshold_used, zero pad
  output logic             m_axis_tlast,  // is_last
  output logic             m_axis_tuser,  // [0] not_ready
  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_wdata_i
);
  import sept_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy;
  logic [7:0] pixel_out;
  logic [THR_W-1:0] thr_used;

  sept_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  sept_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pixel_in_i       (s_axis_tdata),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pixel_out_o      (pixel_out),
    .is_last_o        (m_axis_tlast),
    .threshold_used_o (thr_used),
    .not_ready_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {7'd0, thr_used, pixel_out};

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready)
    else $error("input accepted while frame processing");

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !m_axis_tvalid)
    else $error("result pending during frame processing");

  a_not_ready_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (!m_axis_tlast && m_axis_tdata[7:0] == 8'h00))
    else $error("not-ready beat carries pixel or last");

endmodule
`default_nettype wire
